/* design/tdpt_pkg.sv */
// Shared types and constants for the trial division primality tester.
package tdpt_pkg;

	// Width of the candidate field on the input channel
	localparam int unsigned CandW = 32;

	// Depth of the queue between the front and back parts
	localparam int unsigned QueueDepth = 2;

	// Classification made by the front part for each candidate
	typedef struct packed {
		logic trivial; // answer known without trial division
		logic flag;    // answer when trivial
	} tdpt_class_t;

endpackage

/* design/tdpt_if.sv */
// Valid/ready channel interfaces for the candidate input and the result output.
interface tdpt_cand_if
	import tdpt_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [CandW-1:0] candidate;

	modport source (output valid, output candidate, input ready);
	modport sink (input valid, input candidate, output ready);
endinterface

interface tdpt_flag_if;
	logic valid;
	logic ready;
	logic prime_flag;

	modport source (output valid, output prime_flag, input ready);
	modport sink (input valid, input prime_flag, output ready);
endinterface

/* design/trial_division_primality_test_top.sv */
// Top level of the trial division primality tester.
//
//   channel  | role   | beat fields
//   ---------+--------+-------------------------------
//   cand     | sink   | candidate [31:0], unsigned
//   result   | source | prime_flag [0]
//
// Trivial candidates (below 2, two, even) go through the queue and S_DONE to the result
// register. An odd candidate is tried against odd divisors from 3 up: S_CHECK ends it as
// prime once the divisor square exceeds it, S_DIV runs the bit-serial remainder unit over
// every bit of it, and S_EVAL ends it as composite on a zero remainder. A two-entry queue
// lets the front take new beats meanwhile. Reset clears the queue, sequencer and result
// valid. A stalled result holds, stopping the back part and, once the queue fills, the front.
module trial_division_primality_test_top
	import tdpt_pkg::*;
#(
	parameter int unsigned NUMBER_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	tdpt_cand_if.sink   cand,
	tdpt_flag_if.source result
);

	localparam int unsigned EntryW = NUMBER_BITS + $bits(tdpt_class_t);

	logic                   q_push;
	logic [NUMBER_BITS-1:0] push_num;
	tdpt_class_t            push_class;
	logic                   q_pop;
	logic                   q_full;
	logic                   q_empty;
	logic [EntryW-1:0]      pop_data;
	logic [NUMBER_BITS-1:0] pop_num;
	tdpt_class_t            pop_class;

	assign pop_num   = pop_data[EntryW-1 -: NUMBER_BITS];
	assign pop_class = tdpt_class_t'(pop_data[$bits(tdpt_class_t)-1:0]);

	tdpt_front #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_front (
		.cand    (cand),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_num   (push_num),
		.q_class (push_class)
	);

	tdpt_queue #(
		.WIDTH (EntryW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_num, push_class}),
		.pop       (q_pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	tdpt_back #(
		.NUMBER_BITS (NUMBER_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_num   (pop_num),
		.q_class (pop_class),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

/* design/tdpt_front.sv */
// Front part: accepts candidates, masks them to the datapath width and classifies them.
module tdpt_front
	import tdpt_pkg::*;
#(
	parameter int unsigned NUMBER_BITS = 32
) (
	tdpt_cand_if.sink          cand,
	input  logic               q_full,
	output logic               q_push,
	output logic [NUMBER_BITS-1:0] q_num,
	output tdpt_class_t        q_class
);

	logic [NUMBER_BITS-1:0] num;

	// Cut or zero-extend the candidate to the datapath width
	assign num = NUMBER_BITS'(cand.candidate);

	// Beat is taken whenever the queue has room
	assign cand.ready = !q_full;
	assign q_push     = cand.valid && !q_full;
	assign q_num      = num;

	// Zero and one: not prime; two: prime; other even numbers: composite; odd ones go to trial division
	always_comb begin
		q_class.trivial = 1'b1;
		q_class.flag    = 1'b0;
		priority if (num < NUMBER_BITS'(2)) begin
			q_class.flag = 1'b0;
		end else if (num == NUMBER_BITS'(2)) begin
			q_class.flag = 1'b1;
		end else if (!num[0]) begin
			q_class.flag = 1'b0;
		end else begin
			q_class.trivial = 1'b0;
		end
	end

endmodule

/* design/tdpt_queue.sv */
// Small FIFO that decouples the front part from the back part.
module tdpt_queue
	import tdpt_pkg::*;
#(
	parameter int unsigned WIDTH = 34
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	logic [WIDTH-1:0] mem_q [QueueDepth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CntW'(QueueDepth));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/tdpt_back.sv */
// Back part: trial division with a bit-serial remainder unit and the result register.
module tdpt_back
	import tdpt_pkg::*;
#(
	parameter int unsigned NUMBER_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	input  logic [NUMBER_BITS-1:0] q_num,
	input  tdpt_class_t            q_class,
	output logic                   q_pop,
	tdpt_flag_if.source            result
);

	localparam int unsigned N    = NUMBER_BITS;
	localparam int unsigned CntW = $clog2(N);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIV,
		S_EVAL,
		S_DONE
	} state_t;

	state_t        state_q;
	logic [N-1:0]  num_q;
	logic [N-1:0]  shf_q;
	logic [N-1:0]  div_q;
	logic [N-1:0]  rem_q;
	logic [N:0]    sq_q;
	logic [CntW-1:0] cnt_q;
	logic          flag_q;
	logic          out_valid_q;
	logic          out_flag_q;

	logic [N:0]    rem_sh;
	logic          rem_ge;
	logic [N:0]    rem_nx;
	logic [N:0]    sq_nx;
	logic          out_free;

	// One restoring remainder step: bring in the next bit of the number
	assign rem_sh = {rem_q, shf_q[N-1]};
	assign rem_ge = (rem_sh >= {1'b0, div_q});
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, div_q}) : rem_sh;

	// (d+2)^2 = d^2 + 4d + 4
	assign sq_nx = sq_q + ({1'b0, div_q} << 2) + (N+1)'(4);

	assign out_free          = !out_valid_q || result.ready;
	assign q_pop             = (state_q == S_IDLE) && !q_empty;
	assign result.valid      = out_valid_q;
	assign result.prime_flag = out_flag_q;

	// Sequencer, datapath registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_flag_q  <= 1'b0;
			num_q       <= '0;
			shf_q       <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			sq_q        <= '0;
			cnt_q       <= '0;
			flag_q      <= 1'b0;
		end else begin
			// Result taken; S_DONE reloads it in the same cycle when it has one
			if (out_valid_q && result.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						num_q  <= q_num;
						flag_q <= q_class.flag;
						div_q  <= N'(3);
						sq_q   <= (N+1)'(9);
						state_q <= q_class.trivial ? S_DONE : S_CHECK;
					end
				end
				S_CHECK: begin
					// Divisor square beyond the number: no factor left
					if (sq_q > {1'b0, num_q}) begin
						flag_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						rem_q   <= '0;
						shf_q   <= num_q;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_nx[N-1:0];
					shf_q <= shf_q << 1;
					cnt_q <= cnt_q + CntW'(1);
					if (cnt_q == CntW'(N - 1)) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (rem_q == '0) begin
						flag_q  <= 1'b0;
						state_q <= S_DONE;
					end else begin
						div_q   <= div_q + N'(2);
						sq_q    <= sq_nx;
						state_q <= S_CHECK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_flag_q  <= flag_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
